FILE: src/vtds_pkg.sv
`timescale 1ns / 1ps

package vtds_pkg;

   // Field widths
   localparam int unsigned ValueWidth   = 32;
   localparam int unsigned CharWidth    = 7;
   localparam int unsigned CountWidth   = 6;
   localparam int unsigned DigitWidth   = 4;
   localparam int unsigned BcdDigits    = 10;
   localparam int unsigned BufWidth     = BcdDigits * DigitWidth;
   localparam int unsigned PadWidth     = BufWidth - ValueWidth;
   localparam int unsigned IterWidth    = $clog2(ValueWidth);
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   // Display base codes
   typedef enum logic [1:0] {
      BASE_BIN  = 2'd0,
      BASE_HEX  = 2'd1,
      BASE_DEC  = 2'd2,
      BASE_NONE = 2'd3
   } base_type;

   // Operand width codes (code three behaves as 32 bits)
   localparam logic [1:0] WSEL_8  = 2'd0;
   localparam logic [1:0] WSEL_16 = 2'd1;
   localparam logic [1:0] WSEL_32 = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_NUMBER_BASE  = 2'd0;
   localparam logic [1:0] REG_SIGNED_MODE  = 2'd1;
   localparam logic [1:0] REG_WIDTH_SELECT = 2'd2;

   // Characters
   localparam logic [CharWidth-1:0] ASCII_ZERO  = 7'd48;
   localparam logic [CharWidth-1:0] ASCII_ALPHA = 7'd55;
   localparam logic [CharWidth-1:0] ASCII_MINUS = 7'd45;

   // Digit positions held in the buffer for each base
   localparam logic [CountWidth-1:0] BIN_DIGITS = 6'd32;
   localparam logic [CountWidth-1:0] HEX_DIGITS = 6'd8;
   localparam logic [CountWidth-1:0] DEC_DIGITS = 6'd10;

   // Control from the sequencer to the character emitter
   typedef struct packed {
      logic                  load;
      base_type              base;
      logic                  neg;
      logic [CountWidth-1:0] limit;
   } emit_ctl_type;

   function automatic logic [CountWidth-1:0] digit_limit(base_type b, logic [1:0] wsel);
      logic [CountWidth-1:0] w;
      logic [CountWidth-1:0] d;
      begin
         case (wsel)
            WSEL_8: begin
               w = 6'd8;
               d = 6'd3;
            end
            WSEL_16: begin
               w = 6'd16;
               d = 6'd5;
            end
            default: begin
               w = 6'd32;
               d = 6'd10;
            end
         endcase
         case (b)
            BASE_BIN: digit_limit = w;
            BASE_HEX: digit_limit = w >> 2;
            default:  digit_limit = d;
         endcase
      end
   endfunction

   function automatic logic [CharWidth-1:0] to_ascii(logic [DigitWidth-1:0] d);
      begin
         if (d < 4'd10) begin
            to_ascii = ASCII_ZERO + {3'b000, d};
         end else begin
            to_ascii = ASCII_ALPHA + {3'b000, d};
         end
      end
   endfunction

endpackage

FILE: src/vtds_req_if.sv
`timescale 1ns / 1ps

interface vtds_req_if import vtds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ValueWidth-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

FILE: src/vtds_rsp_if.sv
`timescale 1ns / 1ps

interface vtds_rsp_if import vtds_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CharWidth-1:0]  character;
   logic                  last;
   logic [CountWidth-1:0] digit_count;
   logic [CountWidth-1:0] digit_limit;

   modport source (output valid, output character, output last, output digit_count,
                   output digit_limit, input ready);
   modport sink   (input valid, input character, input last, input digit_count,
                   input digit_limit, output ready);
endinterface

FILE: src/vtds_dabble.sv
`timescale 1ns / 1ps

// Bit-serial binary to BCD: one shift-add-3 step per cycle
module vtds_dabble import vtds_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [ValueWidth-1:0] operand,
   output logic                  done,
   output logic [BufWidth-1:0]   bcd
);

   logic [ValueWidth-1:0] bin_ff;
   logic [BufWidth-1:0]   bcd_ff;
   logic [BufWidth-1:0]   adj_in;
   logic [IterWidth-1:0]  iter_ff;
   logic                  busy_ff;
   logic                  done_ff;

   // Add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < BcdDigits; i++) begin
         if (bcd_ff[i*DigitWidth +: DigitWidth] >= 4'd5) begin
            adj_in[i*DigitWidth +: DigitWidth] = bcd_ff[i*DigitWidth +: DigitWidth] + 4'd3;
         end else begin
            adj_in[i*DigitWidth +: DigitWidth] = bcd_ff[i*DigitWidth +: DigitWidth];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         // done pulses for one cycle after the final shift
         done_ff <= !start && busy_ff && (iter_ff == IterWidth'(ValueWidth - 1));
         if (start) begin
            bin_ff  <= operand;
            bcd_ff  <= '0;
            iter_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            bcd_ff  <= {adj_in[BufWidth-2:0], bin_ff[ValueWidth-1]};
            bin_ff  <= {bin_ff[ValueWidth-2:0], 1'b0};
            iter_ff <= iter_ff + 1'b1;
            if (iter_ff == IterWidth'(ValueWidth - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

FILE: src/vtds_emit.sv
`timescale 1ns / 1ps

// Digit shift register: drops leading zeros, then sends one character per transfer
module vtds_emit import vtds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  emit_ctl_type        ctl,
   input  logic [BufWidth-1:0] load_data,
   output logic                busy,
   vtds_rsp_if.source          rsp
);

   typedef enum logic [1:0] {
      E_IDLE,
      E_SKIP,
      E_SIGN,
      E_DIGIT
   } emit_state_type;

   emit_state_type        state_ff;
   logic [BufWidth-1:0]   buf_ff;
   logic [CountWidth-1:0] remain_ff;
   base_type              base_ff;
   logic                  neg_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] limit_ff;
   logic                  out_valid_ff;
   logic [CharWidth-1:0]  out_char_ff;
   logic                  out_last_ff;

   logic [DigitWidth-1:0] cur_digit;
   logic [BufWidth-1:0]   shift_in;
   logic                  can_load;
   logic                  out_load;

   // Current digit sits at the top of the buffer
   always_comb begin
      if (base_ff == BASE_BIN) begin
         cur_digit = {3'b000, buf_ff[BufWidth-1]};
         shift_in  = {buf_ff[BufWidth-2:0], 1'b0};
      end else begin
         cur_digit = buf_ff[BufWidth-1 -: DigitWidth];
         shift_in  = {buf_ff[BufWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
      end
   end

   assign can_load = !out_valid_ff || rsp.ready;
   assign out_load = ((state_ff == E_SIGN) || (state_ff == E_DIGIT)) && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= E_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // Output register: filled with a new character or emptied by the transfer
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            E_IDLE: begin
               if (ctl.load) begin
                  buf_ff   <= load_data;
                  base_ff  <= ctl.base;
                  neg_ff   <= ctl.neg;
                  limit_ff <= ctl.limit;
                  case (ctl.base)
                     BASE_BIN: remain_ff <= BIN_DIGITS;
                     BASE_HEX: remain_ff <= HEX_DIGITS;
                     default:  remain_ff <= DEC_DIGITS;
                  endcase
                  state_ff <= E_SKIP;
               end
            end
            // One leading zero dropped per cycle; the last digit always stays
            E_SKIP: begin
               if (cur_digit == '0 && remain_ff != 6'd1) begin
                  buf_ff    <= shift_in;
                  remain_ff <= remain_ff - 1'b1;
               end else begin
                  count_ff <= (cur_digit == '0) ? '0 : remain_ff;
                  state_ff <= neg_ff ? E_SIGN : E_DIGIT;
               end
            end
            E_SIGN: begin
               if (can_load) begin
                  out_char_ff  <= ASCII_MINUS;
                  out_last_ff  <= 1'b0;
                  state_ff     <= E_DIGIT;
               end
            end
            E_DIGIT: begin
               if (can_load) begin
                  out_char_ff  <= to_ascii(cur_digit);
                  out_last_ff  <= (remain_ff == 6'd1);
                  buf_ff       <= shift_in;
                  remain_ff    <= remain_ff - 1'b1;
                  if (remain_ff == 6'd1) begin
                     state_ff <= E_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign busy            = (state_ff != E_IDLE) || out_valid_ff;
   assign rsp.valid       = out_valid_ff;
   assign rsp.character   = out_char_ff;
   assign rsp.last        = out_last_ff;
   assign rsp.digit_count = count_ff;
   assign rsp.digit_limit = limit_ff;

endmodule

FILE: src/value_to_digit_string_unit.sv
`timescale 1ns / 1ps

// Channel | Direction | Carries
// --------+-----------+---------------------------------------------------
// req     | in        | value (32 bits), valid/ready
// rsp     | out       | character, last, digit_count, digit_limit, v/r
// csr     | in (APB)  | number_base @0x0, signed_mode @0x4, width_select @0x8
//
// One value at a time. A decimal value first passes through the shift-add-3 BCD
// converter; binary and hex values go straight to the emitter, which drops the
// leading zeros at one per cycle and then sends the characters. The longest
// text is eleven characters, a negative decimal.
// A stalled rsp holds the current character; no new value is taken until the last
// character has been transferred. Reset is synchronous.
module value_to_digit_string_unit import vtds_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   vtds_req_if.sink                req,
   vtds_rsp_if.source              rsp,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_EMIT
   } seq_state_type;

   seq_state_type         state_ff;
   base_type              number_base_ff;
   logic                  signed_mode_ff;
   logic [1:0]            width_select_ff;
   logic                  neg_ff;

   logic                  accept;
   logic [ValueWidth-1:0] ext_in;
   logic                  neg_in;
   logic [ValueWidth-1:0] mag_in;
   logic                  dab_done;
   logic [BufWidth-1:0]   dab_bcd;
   logic                  emit_busy;
   emit_ctl_type          emit_ctl;
   logic [BufWidth-1:0]   emit_data;

   // Register file
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff  <= BASE_DEC;
         signed_mode_ff  <= 1'b0;
         width_select_ff <= WSEL_32;
      end else if (psel && penable && pwrite) begin
         case (paddr[3:2])
            REG_NUMBER_BASE:  number_base_ff  <= base_type'(pwdata[1:0]);
            REG_SIGNED_MODE:  signed_mode_ff  <= pwdata[0];
            REG_WIDTH_SELECT: width_select_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_NUMBER_BASE:  prdata = {30'd0, number_base_ff};
         REG_SIGNED_MODE:  prdata = {31'd0, signed_mode_ff};
         REG_WIDTH_SELECT: prdata = {30'd0, width_select_ff};
         default:          prdata = '0;
      endcase
   end

   // Sign extension and magnitude for signed decimal
   always_comb begin
      case (width_select_ff)
         WSEL_8:  ext_in = {{24{req.value[7]}}, req.value[7:0]};
         WSEL_16: ext_in = {{16{req.value[15]}}, req.value[15:0]};
         default: ext_in = req.value;
      endcase
      neg_in = signed_mode_ff && ext_in[ValueWidth-1];
      if (!signed_mode_ff) begin
         mag_in = req.value;
      end else if (neg_in) begin
         mag_in = ~ext_in + 1'b1;
      end else begin
         mag_in = ext_in;
      end
   end

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;

   // Hand-off to the emitter
   always_comb begin
      emit_ctl.load  = (accept && (number_base_ff == BASE_BIN ||
                                   number_base_ff == BASE_HEX)) ||
                       (state_ff == S_CONV && dab_done);
      emit_ctl.base  = number_base_ff;
      emit_ctl.neg   = (state_ff == S_CONV) && neg_ff;
      emit_ctl.limit = digit_limit(number_base_ff, width_select_ff);
      if (state_ff == S_CONV) begin
         emit_data = dab_bcd;
      end else begin
         emit_data = {req.value, {PadWidth{1'b0}}};
      end
   end

   // Sequencer; base code three takes the value and produces nothing
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         neg_ff   <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  case (number_base_ff)
                     BASE_DEC: begin
                        neg_ff   <= neg_in;
                        state_ff <= S_CONV;
                     end
                     BASE_BIN, BASE_HEX: state_ff <= S_EMIT;
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_CONV: begin
               if (dab_done) begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!emit_busy) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   vtds_dabble u_dabble (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && number_base_ff == BASE_DEC),
      .operand (mag_in),
      .done    (dab_done),
      .bcd     (dab_bcd)
   );

   vtds_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (emit_ctl),
      .load_data (emit_data),
      .busy      (emit_busy),
      .rsp       (rsp)
   );

endmodule

FILE: sim/value_to_digit_string_unit_test.sv
`timescale 1ns / 1ps

module value_to_digit_string_unit_test;
   import vtds_pkg::*;

   localparam int unsigned RANDOM_VALUES = 245;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned DRAIN_CYCLES  = 100;
   localparam int unsigned HOLD_CYCLES   = 500;
   localparam int unsigned HOLD_AFTER    = 80;
   localparam int unsigned CYCLE_LIMIT   = 1000000;
   localparam int unsigned MAX_REPORTS   = 10;

   // Width code not named in the package
   localparam logic [1:0] WSEL_WIDE = 2'd3;

   localparam logic SGN_OFF = 1'b0;
   localparam logic SGN_ON  = 1'b1;

   localparam logic [CharWidth-1:0] CHAR_ZERO   = 7'd48;
   localparam logic [CharWidth-1:0] CHAR_LETTER = 7'd55;
   localparam logic [CharWidth-1:0] CHAR_MINUS  = 7'd45;

   // One character of formatted text as it leaves the block
   typedef struct packed {
      logic [CharWidth-1:0]  character;
      logic                  last;
      logic [CountWidth-1:0] count;
      logic [CountWidth-1:0] limit;
   } glyph_type;

   // Directed stimulus: raw register words, the value, and typed text where obvious
   typedef struct packed {
      logic [31:0]           base_wr;
      logic [31:0]           sign_wr;
      logic [31:0]           width_wr;
      logic [31:0]           value;
      logic                  typed;
      logic [87:0]           text;
      logic [CountWidth-1:0] count;
      logic [CountWidth-1:0] limit;
   } probe_type;

   typedef enum int {FLOW_FREE, FLOW_COIN, FLOW_SPARSE, FLOW_TOGGLE} flow_mode_type;

   localparam int NUM_PROBES = 25;
   localparam probe_type PROBES [NUM_PROBES] = '{
      '{BASE_DEC, SGN_OFF, WSEL_32, 32'h0000_0000, 1'b1, "0", 6'd0, 6'd10},
      '{BASE_DEC, SGN_OFF, WSEL_32, 32'hFFFF_FFFF, 1'b1, "4294967295", 6'd10, 6'd10},
      '{BASE_DEC, SGN_OFF, WSEL_32, 32'h0000_3039, 1'b0, "", 6'd0, 6'd0},
      '{BASE_DEC, SGN_ON,  WSEL_32, 32'h8000_0000, 1'b1, "-2147483648", 6'd10, 6'd10},
      '{BASE_DEC, SGN_ON,  WSEL_32, 32'hFFFF_FFFF, 1'b1, "-1", 6'd1, 6'd10},
      '{BASE_DEC, SGN_ON,  WSEL_32, 32'h7FFF_FFFF, 1'b1, "2147483647", 6'd10, 6'd10},
      '{BASE_DEC, SGN_ON,  WSEL_8,  32'h1234_5680, 1'b1, "-128", 6'd3, 6'd3},
      '{BASE_DEC, SGN_ON,  WSEL_8,  32'hFFFF_FF7F, 1'b1, "127", 6'd3, 6'd3},
      '{BASE_DEC, SGN_ON,  WSEL_16, 32'h0000_8000, 1'b1, "-32768", 6'd5, 6'd5},
      '{BASE_DEC, SGN_ON,  WSEL_16, 32'hABCD_0000, 1'b1, "0", 6'd0, 6'd5},
      '{BASE_DEC, SGN_OFF, WSEL_8,  32'h0000_00FF, 1'b1, "255", 6'd3, 6'd3},
      '{BASE_DEC, SGN_OFF, WSEL_8,  32'hFFFF_FF00, 1'b0, "", 6'd0, 6'd0},
      '{BASE_HEX, SGN_OFF, WSEL_32, 32'h0000_0000, 1'b1, "0", 6'd0, 6'd8},
      '{BASE_HEX, SGN_OFF, WSEL_32, 32'hFFFF_FFFF, 1'b1, "FFFFFFFF", 6'd8, 6'd8},
      '{BASE_HEX, SGN_OFF, WSEL_32, 32'h0ABC_DEF9, 1'b0, "", 6'd0, 6'd0},
      '{BASE_HEX, SGN_OFF, WSEL_8,  32'h1234_5678, 1'b1, "12345678", 6'd8, 6'd2},
      '{BASE_HEX, SGN_ON,  WSEL_16, 32'h0000_FFFF, 1'b1, "FFFF", 6'd4, 6'd4},
      '{BASE_BIN, SGN_OFF, WSEL_32, 32'h0000_0000, 1'b1, "0", 6'd0, 6'd32},
      '{BASE_BIN, SGN_OFF, WSEL_32, 32'h0000_0001, 1'b1, "1", 6'd1, 6'd32},
      '{BASE_BIN, SGN_OFF, WSEL_32, 32'h8000_0000, 1'b0, "", 6'd0, 6'd0},
      '{BASE_BIN, SGN_OFF, WSEL_8,  32'h0000_0005, 1'b1, "101", 6'd3, 6'd8},
      '{BASE_BIN, SGN_ON,  WSEL_16, 32'hFFFF_FFFF, 1'b0, "", 6'd0, 6'd0},
      '{BASE_DEC, SGN_ON,  WSEL_WIDE, 32'h8000_0000, 1'b1, "-2147483648", 6'd10, 6'd10},
      '{BASE_NONE, SGN_ON, WSEL_WIDE, 32'h0000_1234, 1'b0, "", 6'd0, 6'd0},
      // upper register bits set: decodes as unsigned decimal, 16 bits
      '{32'hFFFF_FFF6, 32'hFFFF_FFFE, 32'h0000_0005, 32'h0001_0000, 1'b1, "65536",
        6'd5, 6'd5}
   };

   logic                    clock;
   logic                    reset;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   vtds_req_if req_ch ();
   vtds_rsp_if rsp_ch ();

   value_to_digit_string_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the formatter registers, decoded as the block sees them
   base_type    cfg_base   = BASE_DEC;
   logic        cfg_signed = 1'b0;
   logic [1:0]  cfg_width  = WSEL_32;
   logic [31:0] reg_shadow [3] = '{32'd2, 32'd0, 32'd2};

   glyph_type   pending_glyphs [$];
   int unsigned glyph_errors    = 0;
   int unsigned accepted_values = 0;
   int unsigned cycle_count     = 0;

   always #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL value_to_digit_string_unit");
         $finish;
      end
   end

   // Expected text of one value under the current register settings
   function automatic void format_value(input logic [31:0] v);
      logic [CharWidth-1:0] text [$];
      logic [CharWidth-1:0] rev [$];
      logic [31:0]          mag;
      logic [31:0]          mask;
      logic [3:0]           nib;
      int unsigned          w;
      int unsigned          lim;
      int unsigned          digits;
      int                   top;
      int                   i;
      if (cfg_base == BASE_NONE) return;
      case (cfg_width)
         WSEL_8:  w = 8;
         WSEL_16: w = 16;
         default: w = 32;
      endcase
      case (cfg_base)
         BASE_BIN: lim = w;
         BASE_HEX: lim = w / 4;
         default:  lim = (w == 8) ? 3 : (w == 16) ? 5 : 10;
      endcase
      case (cfg_base)
         BASE_BIN: begin
            top = 31;
            while (top > 0 && !v[top]) top--;
            for (i = top; i >= 0; i--) text.push_back(CHAR_ZERO + 7'(v[i]));
            digits = text.size();
         end
         BASE_HEX: begin
            top = 7;
            while (top > 0 && v[top*4 +: 4] == 4'd0) top--;
            for (i = top; i >= 0; i--) begin
               nib = v[i*4 +: 4];
               text.push_back((nib < 4'd10) ? CHAR_ZERO + 7'(nib) : CHAR_LETTER + 7'(nib));
            end
            digits = text.size();
         end
         default: begin
            mag = v;
            if (cfg_signed) begin
               // sign-extend from the operand width first
               if (w < 32) begin
                  mask = (32'h1 << w) - 32'h1;
                  mag  = v & mask;
                  if (mag[w-1]) mag = mag | ~mask;
               end
               if (mag[31]) begin
                  text.push_back(CHAR_MINUS);
                  mag = -mag;
               end
            end
            do begin
               rev.push_front(CHAR_ZERO + 7'(mag % 32'd10));
               mag = mag / 32'd10;
            end while (mag != 32'd0);
            digits = rev.size();
            text = {text, rev};
         end
      endcase
      // a lone zero counts as no digits
      if (digits == 1 && text[text.size()-1] == CHAR_ZERO) digits = 0;
      foreach (text[k])
         pending_glyphs.push_back('{text[k], k == text.size() - 1, 6'(digits), 6'(lim)});
   endfunction

   // Expected glyphs from typed text, right-justified in the field
   function automatic void expect_text(input logic [87:0] text,
                                       input logic [CountWidth-1:0] count,
                                       input logic [CountWidth-1:0] limit);
      logic [CharWidth-1:0] chars [$];
      int                   i;
      for (i = 10; i >= 0; i--)
         if (text[i*8 +: 8] != 8'd0) chars.push_back(text[i*8 +: 7]);
      foreach (chars[k])
         pending_glyphs.push_back('{chars[k], k == chars.size() - 1, count, limit});
   endfunction

   // Random value, biased towards edges of the current operand width
   function automatic logic [31:0] pick_value();
      logic [31:0] mask;
      logic [31:0] pivot;
      case (cfg_width)
         WSEL_8:  mask = 32'h0000_00FF;
         WSEL_16: mask = 32'h0000_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 7))
         0, 1, 2: return $urandom();
         3:       return $urandom_range(0, 20);
         4:       return 32'h1 << $urandom_range(0, 31);
         5:       return 32'hFFFF_FFFF >> $urandom_range(0, 31);
         6: begin
            case ($urandom_range(0, 3))
               0:       pivot = 32'h0;
               1:       pivot = mask >> 1;
               2:       pivot = (mask >> 1) + 32'h1;
               default: pivot = mask;
            endcase
            return ($urandom() & ~mask) | (pivot & mask);
         end
         default: return $urandom() >> $urandom_range(1, 31);
      endcase
   endfunction

   // Upper register bits are don't-care; fill them now and then
   function automatic logic [31:0] with_noise(input logic [31:0] field, input int bits);
      if ($urandom_range(0, 3) == 0) return ($urandom() << bits) | field;
      return field;
   endfunction

   // APB write: setup, then access; the register takes it on the access edge
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CsrAddrWidth'({idx, 2'b00});
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      reg_shadow[idx] = data;
      case (idx)
         REG_NUMBER_BASE:  cfg_base   = base_type'(data[1:0]);
         REG_SIGNED_MODE:  cfg_signed = data[0];
         REG_WIDTH_SELECT: cfg_width  = data[1:0];
         default: ;
      endcase
   endtask

   // Offer one value and hold it until the transfer
   task automatic offer_value(input logic [31:0] v, input bit predict);
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      accepted_values++;
      if (predict) format_value(v);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Block idle: every character out, then allow for a value still in flight
   task automatic settle_block();
      req_ch.valid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: directed table, then random phases of bursts
   initial begin
      int unsigned random_count;
      int unsigned phase_len;
      int unsigned burst_left;
      int          p;
      int          n;
      base_type    next_base;
      clock        = 1'b0;
      reset        = 1'b1;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      random_count = 0;
      burst_left   = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (p = 0; p < NUM_PROBES; p++) begin
         if (PROBES[p].base_wr != reg_shadow[REG_NUMBER_BASE] ||
             PROBES[p].sign_wr != reg_shadow[REG_SIGNED_MODE] ||
             PROBES[p].width_wr != reg_shadow[REG_WIDTH_SELECT]) begin
            settle_block();
            if (PROBES[p].base_wr != reg_shadow[REG_NUMBER_BASE])
               write_reg(REG_NUMBER_BASE, PROBES[p].base_wr);
            if (PROBES[p].sign_wr != reg_shadow[REG_SIGNED_MODE])
               write_reg(REG_SIGNED_MODE, PROBES[p].sign_wr);
            if (PROBES[p].width_wr != reg_shadow[REG_WIDTH_SELECT])
               write_reg(REG_WIDTH_SELECT, PROBES[p].width_wr);
         end
         offer_value(PROBES[p].value, !PROBES[p].typed);
         if (PROBES[p].typed) expect_text(PROBES[p].text, PROBES[p].count, PROBES[p].limit);
         if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 6));
      end

      while (random_count < RANDOM_VALUES) begin
         settle_block();
         next_base = ($urandom_range(0, 11) == 0) ? BASE_NONE
                                                  : base_type'($urandom_range(0, 2));
         write_reg(REG_NUMBER_BASE, with_noise(32'(next_base), 2));
         write_reg(REG_SIGNED_MODE, with_noise($urandom_range(0, 1), 1));
         write_reg(REG_WIDTH_SELECT, with_noise($urandom_range(0, 3), 2));
         phase_len = (cfg_base == BASE_NONE) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         for (n = 0; n < phase_len; n++) begin
            offer_value(pick_value(), 1'b1);
            if (cfg_base != BASE_NONE) random_count++;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 10);
               if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
            end else begin
               burst_left--;
            end
         end
      end

      // drain and finish
      req_ch.valid <= 1'b0;
      while (pending_glyphs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (glyph_errors == 0) begin
         $display("PASS value_to_digit_string_unit");
      end else begin
         $display("FAIL value_to_digit_string_unit");
      end
      $finish;
   end

   // Receiver flow control: runs of free flow, random, sparse and alternating stalls, one long hold-off
   initial begin
      flow_mode_type mode;
      int unsigned   run_left;
      int unsigned   hold_left;
      bit            held;
      bit            phase;
      rsp_ch.ready = 1'b0;
      mode         = FLOW_FREE;
      run_left     = 0;
      hold_left    = 0;
      held         = 1'b0;
      phase        = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (!held && accepted_values >= HOLD_AFTER && req_ch.valid === 1'b1) begin
            // sender is busy offering: stall long enough to back the block up
            held = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               mode     = flow_mode_type'($urandom_range(0, 3));
               run_left = $urandom_range(20, 200);
            end
            run_left--;
            phase = !phase;
            case (mode)
               FLOW_FREE:   rsp_ch.ready <= 1'b1;
               FLOW_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               FLOW_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ch.ready <= phase;
            endcase
         end
      end
   end

   // Compare each transferred character with the oldest expectation
   always @(posedge clock) begin : check_glyphs
      glyph_type got;
      glyph_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = '{rsp_ch.character, rsp_ch.last, rsp_ch.digit_count, rsp_ch.digit_limit};
         if (pending_glyphs.size() == 0) begin
            glyph_errors++;
            if (glyph_errors <= MAX_REPORTS)
               $display("unexpected character %0d last %0b count %0d limit %0d at cycle %0d",
                        got.character, got.last, got.count, got.limit, cycle_count);
         end else begin
            want = pending_glyphs.pop_front();
            if (got.character !== want.character || got.last !== want.last ||
                got.count !== want.count || got.limit !== want.limit) begin
               glyph_errors++;
               if (glyph_errors <= MAX_REPORTS)
                  $display("mismatch at cycle %0d (char/last/count/limit): %0s %0s",
                           cycle_count,
                           $sformatf("expected %0d/%0b/%0d/%0d", want.character,
                                     want.last, want.count, want.limit),
                           $sformatf("got %0d/%0b/%0d/%0d", got.character,
                                     got.last, got.count, got.limit));
            end
         end
      end
   end

endmodule

FILE: filelist.f
src/vtds_pkg.sv
src/vtds_req_if.sv
src/vtds_rsp_if.sv
src/vtds_dabble.sv
src/vtds_emit.sv
src/value_to_digit_string_unit.sv
sim/value_to_digit_string_unit_test.sv
